// ===== sv/fpst_pkg.sv =====
// Shared constants, codes and types of the prefix-sum tree block.
`timescale 1ns / 1ps

package fpst_pkg;

	// Tree geometry
	localparam int DEPTH  = 1024;
	localparam int ADDR_W = $clog2(DEPTH);
	// Node numbers run 1..DEPTH; an upward step may reach up to 2*DEPTH
	localparam int NODE_W = $clog2(DEPTH) + 2;

	// Field widths fixed by the item format
	localparam int OP_W    = 2;
	localparam int IDX_W   = 10;
	localparam int DELTA_W = 32;
	localparam int SUM_W   = 64;

	// Opcodes
	localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	// Controller states
	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_QRY_HI,
		ST_QRY_LO,
		ST_QRY_FIN
	} fpst_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load_item;  // latch item, node = index + 1, clear accumulator
		logic load_lo;    // node = low_index for the second walk
		logic walk_rd;    // read node-1, step node down (clear lowest set bit)
		logic walk_sub;   // the read of this walk is subtracted
		logic add_wr;     // write read data + delta at node-1, step node up
		logic clr_start;  // restart the clearing sweep
		logic clr_wr;     // write zero at sweep address, advance sweep
		logic res_load;   // move accumulator into the result register
	} fpst_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic node_zero;  // node is 0: downward walk done
		logic node_over;  // node above DEPTH: upward walk done
		logic clr_last;   // sweep sits on the last entry
	} fpst_stat_t;

endpackage

// ===== sv/fpst_if.sv =====
// Valid/ready channel interfaces for request and response transactions.
`timescale 1ns / 1ps

interface fpst_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [9:0]         index;
	logic [9:0]         low_index;
	logic signed [31:0] delta;

	modport source (output valid, output opcode, output index, output low_index,
		output delta, input ready);
	modport sink (input valid, input opcode, input index, input low_index,
		input delta, output ready);
endinterface

interface fpst_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] range_sum;

	modport source (output valid, output range_sum, input ready);
	modport sink (input valid, input range_sum, output ready);
endinterface

// ===== sv/fpst_datapath.sv =====
// Datapath: node register, tree memory, accumulator, sweep counter, result register.
`timescale 1ns / 1ps

module fpst_datapath
	import fpst_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  fpst_cmd_t               cmd,
	input  logic [IDX_W-1:0]        index,
	input  logic [IDX_W-1:0]        low_index,
	input  logic signed [DELTA_W-1:0] delta,
	output fpst_stat_t              stat,
	output logic signed [SUM_W-1:0] range_sum
);

	logic [SUM_W-1:0]  mem [DEPTH];
	logic [SUM_W-1:0]  rd_data_q;
	logic [SUM_W-1:0]  acc_q;
	logic [SUM_W-1:0]  delta_q;
	logic [SUM_W-1:0]  res_q;
	logic [NODE_W-1:0] node_q;
	logic [NODE_W-1:0] lo_q;
	logic [ADDR_W-1:0] clr_q;
	logic              pend_s1;
	logic              sub_s1;

	logic [NODE_W-1:0] hi_ext;
	logic [NODE_W-1:0] lo_ext;
	logic [NODE_W-1:0] hi_clamp;
	logic [NODE_W-1:0] lo_clamp;
	logic [NODE_W-1:0] node_m1;
	logic [NODE_W-1:0] node_low;
	logic [ADDR_W-1:0] node_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic [SUM_W-1:0]  wr_data;
	logic              mem_we;

	// Clamp positions to the last counter
	assign hi_ext   = NODE_W'(index);
	assign lo_ext   = NODE_W'(low_index);
	assign hi_clamp = (hi_ext > NODE_W'(DEPTH - 1)) ? NODE_W'(DEPTH - 1) : hi_ext;
	assign lo_clamp = (lo_ext > NODE_W'(DEPTH - 1)) ? NODE_W'(DEPTH - 1) : lo_ext;

	// Node arithmetic
	assign node_m1   = node_q - NODE_W'(1);
	assign node_low  = node_q & (~node_q + NODE_W'(1));
	assign node_addr = node_m1[ADDR_W-1:0];

	// Memory write port mux
	assign mem_we  = cmd.add_wr | cmd.clr_wr;
	assign wr_addr = cmd.clr_wr ? clr_q : node_addr;
	assign wr_data = cmd.clr_wr ? '0 : (rd_data_q + delta_q);

	// Tree memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[node_addr];
	end

	// Control registers: node walk, read tracking, sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q  <= '0;
			pend_s1 <= 1'b0;
			sub_s1  <= 1'b0;
			clr_q   <= '0;
		end else begin
			pend_s1 <= cmd.walk_rd;
			sub_s1  <= cmd.walk_sub;
			if (cmd.load_item) begin
				node_q <= hi_clamp + NODE_W'(1);
			end else if (cmd.load_lo) begin
				node_q <= lo_q;
			end else if (cmd.walk_rd) begin
				node_q <= node_q & node_m1;
			end else if (cmd.add_wr) begin
				node_q <= node_q + node_low;
			end
			if (cmd.clr_start) begin
				clr_q <= '0;
			end else if (cmd.clr_wr) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
		end
	end

	// Payload registers: item, accumulator, result
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			lo_q    <= lo_clamp;
			delta_q <= {{(SUM_W - DELTA_W){delta[DELTA_W-1]}}, delta};
			acc_q   <= '0;
		end else if (pend_s1) begin
			acc_q <= sub_s1 ? (acc_q - rd_data_q) : (acc_q + rd_data_q);
		end
		if (cmd.res_load) begin
			res_q <= acc_q;
		end
	end

	assign stat.node_zero = (node_q == '0);
	assign stat.node_over = (node_q > NODE_W'(DEPTH));
	assign stat.clr_last  = (clr_q == ADDR_W'(DEPTH - 1));
	assign range_sum      = res_q;

endmodule

// ===== sv/fpst_ctrl.sv =====
// Controller: state machine sequencing sweeps, tree walks and the response register.
`timescale 1ns / 1ps

module fpst_ctrl
	import fpst_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [OP_W-1:0] in_opcode,
	output logic            in_ready,
	input  logic            out_ready,
	output logic            out_valid,
	output fpst_cmd_t       cmd,
	input  fpst_stat_t      stat
);

	fpst_state_t state_q;
	fpst_state_t state_d;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// State and response valid registers; reset starts the clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					case (in_opcode)
						OP_ADD:   state_d = ST_ADD_RD;
						OP_QUERY: state_d = ST_QRY_HI;
						OP_CLEAR: begin
							cmd.clr_start = 1'b1;
							state_d       = ST_CLR;
						end
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD_RD: begin
				// memory read of node-1 happens every cycle
				if (stat.node_over) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_ADD_WR;
				end
			end
			ST_ADD_WR: begin
				cmd.add_wr = 1'b1;
				state_d    = ST_ADD_RD;
			end
			ST_QRY_HI: begin
				if (stat.node_zero) begin
					cmd.load_lo = 1'b1;
					state_d     = ST_QRY_LO;
				end else begin
					cmd.walk_rd = 1'b1;
				end
			end
			ST_QRY_LO: begin
				if (stat.node_zero) begin
					state_d = ST_QRY_FIN;
				end else begin
					cmd.walk_rd  = 1'b1;
					cmd.walk_sub = 1'b1;
				end
			end
			ST_QRY_FIN: begin
				// wait for room in the response register
				if (slot_free) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== sv/fenwick_prefix_sum_tree.sv =====
// Top level of the binary indexed prefix-sum tree over 64-bit counters.
//
// Requests arrive on req (valid/ready): opcode, index, low_index, delta.
// Add puts delta at index; query returns the wrapping sum over
// low_index..index on rsp; clear zeroes every counter. Indices above
// DEPTH-1 clamp. Add, clear and unused opcodes give no response.
// One request is worked at a time; req.ready is high only when idle.
// Add: accept, then for each tree node on the upward path one memory read
// and one write, then a last read state that sees the walk leave the tree.
// Query: accept, then the two downward walks from index+1 and low_index
// (one read per cycle, each read accumulated in the cycle after it), then
// the load of the response register.
// Clear: a sweep over all DEPTH entries, one entry per cycle.
// After reset the same sweep runs before req.ready rises.
// The response sits in an output register; a stalled rsp holds it, and a
// new request is accepted meanwhile; a later query waits at its end until
// the register is free.
`timescale 1ns / 1ps

module fenwick_prefix_sum_tree
	import fpst_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	fpst_req_if.sink     req,
	fpst_rsp_if.source   rsp
);

	fpst_cmd_t  cmd;
	fpst_stat_t stat;

	fpst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_opcode (req.opcode),
		.in_ready  (req.ready),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.cmd       (cmd),
		.stat      (stat)
	);

	fpst_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.index     (req.index),
		.low_index (req.low_index),
		.delta     (req.delta),
		.stat      (stat),
		.range_sum (rsp.range_sum)
	);

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench of the prefix-sum tree: random add, query and clear traffic.
`timescale 1ns / 1ps

module testbench;
	import fpst_pkg::*;

	// Opcode that the block drops without a response
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam int RANDOM_ITEMS  = 1385;
	localparam int TAIL_ITEMS    = 150;   // no idling once this few remain
	localparam int HOLD_AT_ITEM  = 300;   // receiver holds off once here
	localparam int HOLD_CYCLES   = 400;
	localparam int WATCHDOG_MAX  = 20000; // cycles with no transaction at all
	localparam int DRAIN_CYCLES  = 1100;  // covers a trailing clear sweep

	typedef struct {
		logic                      pause;  // hold the sender until all sums are back
		logic [OP_W-1:0]           opcode;
		logic [IDX_W-1:0]          index;
		logic [IDX_W-1:0]          low_index;
		logic signed [DELTA_W-1:0] delta;
	} request_t;

	logic clk;
	logic arst_n;

	fpst_req_if req_ch ();
	fpst_rsp_if rsp_ch ();

	fenwick_prefix_sum_tree u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Own copy of the tree and the sums still owed by the block
	logic [SUM_W-1:0] bit_tree [DEPTH];
	logic [SUM_W-1:0] expected_sums [$];
	request_t         pending_reqs [$];

	int unsigned req_count   = 0;
	int unsigned error_count = 0;
	int unsigned send_gap    = 0;
	int unsigned recv_stall  = 0;
	int unsigned hold_left   = 0;
	bit          hold_done   = 0;
	int unsigned idle_cycles = 0;

	// Tree walks, mirroring the block's node numbering 1..DEPTH
	function automatic logic [SUM_W-1:0] tree_prefix(int unsigned count);
		logic [SUM_W-1:0] acc;
		int unsigned      node;
		acc  = '0;
		node = count;
		while (node > 0) begin
			acc  = acc + bit_tree[node-1];
			node = node & (node - 1);
		end
		return acc;
	endfunction

	task automatic tree_add(int unsigned pos, logic [SUM_W-1:0] amount);
		int unsigned node;
		node = pos + 1;
		while (node <= DEPTH) begin
			bit_tree[node-1] = bit_tree[node-1] + amount;
			node = node + (node & (~node + 1));
		end
	endtask

	task automatic tree_clear();
		for (int i = 0; i < DEPTH; i++)
			bit_tree[i] = '0;
	endtask

	// Update the tree copy for one accepted request; queries owe a sum
	task automatic apply_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
		logic [IDX_W-1:0] lo_idx, logic signed [DELTA_W-1:0] d);
		int unsigned hi;
		int unsigned lo;
		hi = (idx > DEPTH - 1) ? DEPTH - 1 : idx;
		lo = (lo_idx > DEPTH - 1) ? DEPTH - 1 : lo_idx;
		case (op)
			OP_ADD: begin
				tree_add(hi, {{(SUM_W-DELTA_W){d[DELTA_W-1]}}, d});
			end
			OP_QUERY: begin
				expected_sums = {expected_sums, tree_prefix(hi + 1) - tree_prefix(lo)};
			end
			OP_CLEAR: begin
				tree_clear();
			end
			default: ;
		endcase
	endtask

	task automatic push_req(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
		logic [IDX_W-1:0] lo_idx, logic [DELTA_W-1:0] d);
		request_t r;
		r.pause     = 1'b0;
		r.opcode    = op;
		r.index     = idx;
		r.low_index = lo_idx;
		r.delta     = d;
		pending_reqs = {pending_reqs, r};
	endtask

	task automatic push_pause();
		request_t r;
		r = '{pause: 1'b1, opcode: OP_ADD, index: '0, low_index: '0, delta: '0};
		pending_reqs = {pending_reqs, r};
	endtask

	// Indices lean on the ends, on powers of two and on one below them
	function automatic logic [IDX_W-1:0] rand_index();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return IDX_W'((1 << $urandom_range(0, IDX_W - 1)) - 1);
			3: return IDX_W'(1 << $urandom_range(0, IDX_W - 1));
			default: return IDX_W'($urandom_range(0, DEPTH - 1));
		endcase
	endfunction

	function automatic logic [DELTA_W-1:0] rand_delta();
		case ($urandom_range(0, 7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'hffff_ffff;
			3: return DELTA_W'($urandom_range(0, 16)) - 32'd8;
			default: return $urandom;
		endcase
	endfunction

	function automatic bit quiet_phase();
		return (pending_reqs.size() < TAIL_ITEMS) || ((req_count / 100) % 3 == 2);
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stimulus, reset and end of run
	initial begin
		int unsigned made;
		logic [OP_W-1:0] op;
		int unsigned pick;

		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.opcode    = OP_ADD;
		req_ch.index     = '0;
		req_ch.low_index = '0;
		req_ch.delta     = '0;
		rsp_ch.ready     = 1'b0;
		tree_clear();

		// Directed: empty tree, extreme deltas at the ends, odd ranges
		push_req(OP_QUERY, 10'd1023, 10'd0, 32'h0);
		push_req(OP_ADD, 10'd0, 10'd1023, 32'h7fff_ffff);
		push_req(OP_ADD, 10'd1023, 10'd0, 32'h8000_0000);
		push_req(OP_ADD, 10'd511, 10'd0, 32'hffff_ffff);
		push_req(OP_ADD, 10'd512, 10'd0, 32'h0000_0001);
		push_req(OP_QUERY, 10'd1023, 10'd0, 32'hffff_ffff);
		push_req(OP_QUERY, 10'd0, 10'd0, 32'h0);
		push_req(OP_QUERY, 10'd1023, 10'd1023, 32'h0);
		push_req(OP_QUERY, 10'd512, 10'd511, 32'h0);
		// lower end above upper end: negated inner sum, then the empty case
		push_req(OP_QUERY, 10'd5, 10'd600, 32'h0);
		push_req(OP_QUERY, 10'd511, 10'd512, 32'h0);
		push_req(OP_QUERY, 10'd0, 10'd1023, 32'h0);
		// unused opcode must leave the tree alone
		push_req(OP_UNUSED, 10'd7, 10'd3, 32'h0000_04d2);
		push_req(OP_QUERY, 10'd1023, 10'd0, 32'h0);
		push_req(OP_QUERY, 10'd7, 10'd7, 32'h0);
		push_req(OP_CLEAR, 10'd1023, 10'd1023, 32'hffff_ffff);
		push_req(OP_QUERY, 10'd1023, 10'd0, 32'h0);
		push_req(OP_ADD, 10'd767, 10'd0, 32'h8000_0000);
		push_req(OP_ADD, 10'd767, 10'd0, 32'h8000_0000);
		push_req(OP_QUERY, 10'd767, 10'd767, 32'h0);
		push_req(OP_QUERY, 10'd766, 10'd0, 32'h0);
		push_pause();

		// Random traffic; clears are rare since each sweeps the whole store
		made = 0;
		while (made < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 47)
				op = OP_ADD;
			else if (pick < 96)
				op = OP_QUERY;
			else if (pick < 97)
				op = OP_CLEAR;
			else
				op = OP_UNUSED;
			push_req(op, rand_index(), rand_index(), rand_delta());
			if (op != OP_UNUSED)
				made++;
			if (made == RANDOM_ITEMS / 2 && op != OP_UNUSED)
				push_pause();
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || req_ch.valid || expected_sums.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Request driver with random gaps between transactions
	always @(posedge clk) begin : drive_req
		bit       offering;
		request_t nxt;
		if (arst_n) begin
			offering = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				apply_request(req_ch.opcode, req_ch.index, req_ch.low_index, req_ch.delta);
				req_count++;
				offering = 1'b0;
				if (!quiet_phase() && $urandom_range(0, 3) == 0)
					send_gap = $urandom_range(1, 9);
			end
			if (!offering) begin
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (pending_reqs.size() > 0 && pending_reqs[0].pause) begin
					req_ch.valid <= 1'b0;
					if (expected_sums.size() == 0)
						void'(pending_reqs.pop_front());
				end else if (pending_reqs.size() > 0) begin
					nxt = pending_reqs.pop_front();
					req_ch.valid     <= 1'b1;
					req_ch.opcode    <= nxt.opcode;
					req_ch.index     <= nxt.index;
					req_ch.low_index <= nxt.low_index;
					req_ch.delta     <= nxt.delta;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: check sums in order, stall ready at random
	always @(posedge clk) begin : watch_rsp
		logic [SUM_W-1:0] want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_sums.size() == 0) begin
					$error("unexpected transaction: range_sum actual %0d",
						$signed(rsp_ch.range_sum));
					error_count++;
				end else begin
					want = expected_sums.pop_front();
					if (rsp_ch.range_sum !== want) begin
						$error("range_sum mismatch: expected %0d, actual %0d",
							$signed(want), $signed(rsp_ch.range_sum));
						error_count++;
					end
				end
			end

			// one long hold-off so the output register backs up the input
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!hold_done && req_count >= HOLD_AT_ITEM) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				rsp_ch.ready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				rsp_ch.ready <= 1'b0;
			end else if (!quiet_phase() && $urandom_range(0, 5) == 0) begin
				recv_stall = $urandom_range(1, 9) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_MAX) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

endmodule

// ===== fenwick_prefix_sum_tree.f =====
sv/fpst_pkg.sv
sv/fpst_if.sv
sv/fpst_datapath.sv
sv/fpst_ctrl.sv
sv/fenwick_prefix_sum_tree.sv
tb/testbench.sv
